>>> hdl/window_energy_segment_merger_unit_defines.svh
// Assertion macros shared by the checker files of the window energy merger.
// No dependencies; every user must have clk_i and rst_ni in scope.
`ifndef WINDOW_ENERGY_SEGMENT_MERGER_UNIT_DEFINES_SVH
`define WINDOW_ENERGY_SEGMENT_MERGER_UNIT_DEFINES_SVH

// same-cycle implication
`define WESM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wesm check failed");

// next-cycle implication
`define WESM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wesm check failed");

`endif

>>> hdl/wesm_pkg.sv
// Package for the window energy segment merger: beat types, codes, widths.
// No dependencies; used by every module of the block.
`default_nettype none

package wesm_pkg;

  localparam int unsigned HIST_DEPTH_DEF  = 4096;
  localparam int unsigned MAX_WINDOWS_DEF = 64;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  // shared divider and root unit widths
  localparam int unsigned DIV_NW  = 64;
  localparam int unsigned DIV_DW  = 33;
  localparam int unsigned SQRT_W  = 64;

  typedef enum logic [1:0] {
    CMD_PUSH    = 2'd0,
    CMD_ANALYSE = 2'd1,
    CMD_MERGE   = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SKIP  = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef enum logic {
    REG_WINDOW_WIDTH    = 1'b0,
    REG_THRESHOLD_SCALE = 1'b1
  } reg_idx_e;

  typedef struct packed {
    cmd_e               cmd;
    logic signed [15:0] sample_re;
    logic signed [15:0] sample_im;
    logic [31:0]        centre;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] seg_start;
    logic [31:0] seg_end;
    logic [23:0] seg_mean;
    logic        last;
  } out_t;

endpackage

`default_nettype wire

>>> hdl/wesm_div.sv
// Restoring divider, one quotient bit per cycle, shared by analyse and merge.
// Depends on wesm_pkg for its widths.
`default_nettype none

module wesm_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [wesm_pkg::DIV_NW-1:0] dividend_i,
  input  wire logic [wesm_pkg::DIV_DW-1:0] divisor_i,
  output logic                             done_o,
  output logic [wesm_pkg::DIV_NW-1:0]      quotient_o
);
  import wesm_pkg::*;

  localparam int unsigned CW = $clog2(DIV_NW);

  logic              busy_q, busy_d, done_q, done_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [DIV_DW-1:0] rem_q, rem_d, dvs_q, dvs_d;
  logic [DIV_NW-1:0] quo_q, quo_d;
  logic [DIV_DW:0]   sh;
  logic              ge;

  assign sh = {rem_q, quo_q[DIV_NW-1]};
  assign ge = sh >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? DIV_DW'(sh - {1'b0, dvs_q}) : sh[DIV_DW-1:0];
      quo_d = {quo_q[DIV_NW-2:0], ge};
      cnt_d = CW'(cnt_q + 1'b1);
      if (cnt_q == CW'(DIV_NW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

>>> hdl/wesm_sqrt.sv
// Integer square root, two radicand bits per cycle.
// Depends on wesm_pkg for its width.
`default_nettype none

module wesm_sqrt (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [wesm_pkg::SQRT_W-1:0] radicand_i,
  output logic                             done_o,
  output logic [wesm_pkg::SQRT_W/2-1:0]    root_o
);
  import wesm_pkg::*;

  localparam int unsigned CW = $clog2(SQRT_W / 2);

  logic              busy_q, busy_d, done_q, done_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [SQRT_W-1:0] n_q, n_d, r_q, r_d, bit_q, bit_d, trial;

  assign trial = r_q + bit_q;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    n_d    = n_q;
    r_d    = r_q;
    bit_d  = bit_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      n_d    = radicand_i;
      r_d    = '0;
      bit_d  = SQRT_W'(1) << (SQRT_W - 2);
    end else if (busy_q) begin
      if (n_q >= trial) begin
        n_d = n_q - trial;
        r_d = (r_q >> 1) + bit_q;
      end else begin
        r_d = r_q >> 1;
      end
      bit_d = bit_q >> 2;
      cnt_d = CW'(cnt_q + 1'b1);
      if (cnt_q == CW'(SQRT_W / 2 - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    n_q   <= n_d;
    r_q   <= r_d;
    bit_q <= bit_d;
  end

  assign done_o = done_q;
  assign root_o = r_q[SQRT_W/2-1:0];

endmodule

`default_nettype wire

>>> hdl/window_energy_segment_merger_unit.sv
// Top level of the window energy segment merger: sequencer, sample ring, window list.
// Depends on wesm_pkg, wesm_div and wesm_sqrt.
//
// Usage: a command beat is taken on item_i when start_i is high and busy_o low.
// Every command gives one or more result beats on result_o, each shown for one
// cycle with result_valid_o; the last beat of a command carries last. The receiver
// cannot stall, so beats are never held. Configuration (cfg_we_i, cfg_idx_i,
// cfg_data_i) is registered and must only change while idle.
// Push and clear answer straight from idle. Analyse makes one ring read per cycle
// over the window, then takes two quotients on the shared divider and a root.
// Merge steps through the window pairs, using the divider for every join whose
// summed length is not zero, then emits each segment with a window list read.
// The divider gives one quotient bit per cycle, for analyse and for joins.
// Reset empties the window list, clears the sample count and the maximum mean,
// and loads width 64 and scale 128. The ring and list stores are not cleared:
// entries are only read once written.
`default_nettype none

module window_energy_segment_merger_unit #(
  parameter int unsigned HIST_DEPTH  = wesm_pkg::HIST_DEPTH_DEF,
  parameter int unsigned MAX_WINDOWS = wesm_pkg::MAX_WINDOWS_DEF,
  parameter int unsigned SAMPLE_BITS = wesm_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire wesm_pkg::in_t  item_i,
  output logic                busy_o,
  output wesm_pkg::out_t      result_o,
  output logic                result_valid_o,
  input  wire logic           cfg_we_i,
  input  wire logic           cfg_idx_i,
  input  wire logic [15:0]    cfg_data_i
);
  import wesm_pkg::*;

  localparam int unsigned AW   = $clog2(HIST_DEPTH);
  localparam int unsigned DAW  = AW + 1;
  localparam int unsigned TW   = $clog2(MAX_WINDOWS + 1);
  localparam int unsigned WAW  = $clog2(MAX_WINDOWS);
  localparam int unsigned SW   = 2 * SAMPLE_BITS;
  localparam int unsigned ACCW = SAMPLE_BITS + 11;

  typedef enum logic [17:0] {
    S_IDLE    = 18'h00001,
    S_A_CHK   = 18'h00002,
    S_A_ADR   = 18'h00004,
    S_A_SUM   = 18'h00008,
    S_A_DIV   = 18'h00010,
    S_A_SQ    = 18'h00020,
    S_A_SQRT  = 18'h00040,
    S_M_THR   = 18'h00080,
    S_M_LD0   = 18'h00100,
    S_M_LD1   = 18'h00200,
    S_M_STEP  = 18'h00400,
    S_M_EVAL  = 18'h00800,
    S_M_MUL   = 18'h01000,
    S_M_DIV   = 18'h02000,
    S_M_JOIN  = 18'h04000,
    S_M_FLUSH = 18'h08000,
    S_E_RD    = 18'h10000,
    S_E_OUT   = 18'h20000
  } state_e;

  typedef struct packed {
    logic [31:0] s_pos;
    logic [31:0] e_pos;
    logic [23:0] mean;
  } win_t;

  // control state
  state_e        state_q, state_d;
  logic [1:0]    sub_q, sub_d;
  logic [10:0]   ww_q, ww_d;
  logic [15:0]   scale_q, scale_d;
  logic [31:0]   pushed_q, pushed_d;
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [TW-1:0] total_q, total_d;
  logic [23:0]   largest_q, largest_d;
  logic          res_vld_q, res_vld_d, rd_pend_q, rd_pend_d;
  out_t          res_q, res_d;

  // working registers
  logic [31:0]            start_q, start_d, centre_q, centre_d, la_q, la_d, lb_q, lb_d;
  logic                   skip_q, skip_d;
  logic [DAW-1:0]         diff_q, diff_d;
  logic [AW-1:0]          raddr_q, raddr_d;
  logic [10:0]            cnt_q, cnt_d;
  logic signed [ACCW-1:0] sr_q, sr_d, si_q, si_d;
  logic [31:0]            ar_q, ar_d, ai_q, ai_d;
  logic [63:0]            sq_q, sq_d, acc_q, acc_d;
  logic [39:0]            thr_q, thr_d;
  logic [TW-1:0]          j_q, j_d, w_q, w_d, jn;
  win_t                   cur_q, cur_d, b_q, b_d, c_q, c_d;
  logic [32:0]            slen_q, slen_d;

  // shared multiplier, registered
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_q;

  // shared divider and root
  logic        div_start, div_done, sq_start, sq_done;
  logic [63:0] div_dvd, div_quo;
  logic [32:0] div_dvs;
  logic [31:0] sq_root;

  // sample ring
  logic [SW-1:0] ring_mem [HIST_DEPTH];
  logic [SW-1:0] ring_rd_q, ring_wdata;
  logic          ring_we, ring_re;

  // window list
  win_t           win_mem [MAX_WINDOWS];
  win_t           win_rd_q, win_wdata;
  logic           win_we, win_re;
  logic [WAW-1:0] win_waddr, win_raddr;

  logic [10:0]     wsat;
  logic [9:0]      half;
  logic            accept, issue, ta, tb, tc, cvalid, join_ok;
  logic [ACCW-1:0] mag_r, mag_i;
  logic [23:0]     mean_sat;
  logic [DAW-1:0]  wr_ext;

  function automatic logic above(input logic [23:0] m, input logic [39:0] t);
    return {8'd0, m, 8'd0} > t;
  endfunction

  function automatic out_t mk(input status_e st, input win_t w, input logic lst);
    out_t o;
    o.status    = st;
    o.seg_start = w.s_pos;
    o.seg_end   = w.e_pos;
    o.seg_mean  = w.mean;
    o.last      = lst;
    return o;
  endfunction

  assign wsat   = (ww_q < 11'd2) ? 11'd2 : ((ww_q > 11'd1024) ? 11'd1024 : ww_q);
  assign half   = wsat[10:1];
  assign accept = start_i && (state_q == S_IDLE);
  assign issue  = cnt_q != wsat;
  assign jn     = TW'(j_q + 1'b1);
  assign cvalid = jn < total_q;
  assign ta     = above(cur_q.mean, thr_q);
  assign tb     = above(b_q.mean, thr_q);
  assign tc     = cvalid && above(win_rd_q.mean, thr_q);
  assign join_ok = (ta == tb) || (ta && tc);
  assign mag_r  = sr_q[ACCW-1] ? ACCW'(-sr_q) : ACCW'(sr_q);
  assign mag_i  = si_q[ACCW-1] ? ACCW'(-si_q) : ACCW'(si_q);
  assign mean_sat = (|sq_root[31:24]) ? 24'hFF_FFFF : sq_root[23:0];
  assign wr_ext = {1'b0, wr_ptr_q};
  assign ring_wdata = {SAMPLE_BITS'(item_i.sample_im), SAMPLE_BITS'(item_i.sample_re)};

  always_comb begin
    state_d   = state_q;
    sub_d     = sub_q;
    ww_d      = ww_q;
    scale_d   = scale_q;
    pushed_d  = pushed_q;
    wr_ptr_d  = wr_ptr_q;
    total_d   = total_q;
    largest_d = largest_q;
    res_vld_d = 1'b0;
    res_d     = res_q;
    rd_pend_d = 1'b0;
    start_d   = start_q;
    centre_d  = centre_q;
    skip_d    = skip_q;
    diff_d    = diff_q;
    raddr_d   = raddr_q;
    cnt_d     = cnt_q;
    sr_d      = sr_q;
    si_d      = si_q;
    ar_d      = ar_q;
    ai_d      = ai_q;
    sq_d      = sq_q;
    thr_d     = thr_q;
    j_d       = j_q;
    w_d       = w_q;
    cur_d     = cur_q;
    b_d       = b_q;
    c_d       = c_q;
    la_d      = la_q;
    lb_d      = lb_q;
    acc_d     = acc_q;
    slen_d    = slen_q;
    mul_a     = 32'd0;
    mul_b     = 32'd0;
    div_start = 1'b0;
    div_dvd   = acc_q;
    div_dvs   = slen_q;
    sq_start  = 1'b0;
    ring_we   = 1'b0;
    ring_re   = 1'b0;
    win_we    = 1'b0;
    win_waddr = w_q[WAW-1:0];
    win_wdata = cur_q;
    win_re    = 1'b0;
    win_raddr = jn[WAW-1:0];

    if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_WINDOW_WIDTH:    ww_d    = cfg_data_i[10:0];
        REG_THRESHOLD_SCALE: scale_d = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (item_i.cmd)
            CMD_PUSH: begin
              ring_we   = 1'b1;
              pushed_d  = pushed_q + 32'd1;
              wr_ptr_d  = ((wr_ptr_q == AW'(HIST_DEPTH - 1)) || (&pushed_q)) ? '0
                          : AW'(wr_ptr_q + 1'b1);
              res_vld_d = 1'b1;
              res_d     = mk(ST_OK, '0, 1'b1);
            end
            CMD_ANALYSE: begin
              centre_d = item_i.centre;
              start_d  = item_i.centre - {22'd0, half};
              skip_d   = item_i.centre < {22'd0, half};
              state_d  = S_A_CHK;
            end
            CMD_MERGE: begin
              sub_d   = 2'd0;
              state_d = S_M_THR;
            end
            CMD_CLEAR: begin
              total_d   = '0;
              res_vld_d = 1'b1;
              res_d     = mk(ST_OK, '0, 1'b1);
            end
            default: ;
          endcase
        end
      end

      S_A_CHK: begin
        diff_d = DAW'(pushed_q - start_q);
        if (skip_q || (({1'b0, start_q} + 33'(wsat)) > {1'b0, pushed_q}) ||
            ((pushed_q - start_q) > 32'(HIST_DEPTH))) begin
          res_vld_d = 1'b1;
          res_d     = mk(ST_SKIP, '0, 1'b1);
          state_d   = S_IDLE;
        end else begin
          state_d = S_A_ADR;
        end
      end

      S_A_ADR: begin
        // ring slot of the window start, counted back from the write pointer
        raddr_d = (wr_ext >= diff_q) ? AW'(wr_ext - diff_q)
                  : AW'(wr_ext + DAW'(HIST_DEPTH) - diff_q);
        cnt_d   = '0;
        sr_d    = '0;
        si_d    = '0;
        state_d = S_A_SUM;
      end

      S_A_SUM: begin
        if (issue) begin
          ring_re   = 1'b1;
          rd_pend_d = 1'b1;
          raddr_d   = (raddr_q == AW'(HIST_DEPTH - 1)) ? '0 : AW'(raddr_q + 1'b1);
          cnt_d     = 11'(cnt_q + 1'b1);
        end
        if (rd_pend_q) begin
          sr_d = sr_q + ACCW'($signed(ring_rd_q[SAMPLE_BITS-1:0]));
          si_d = si_q + ACCW'($signed(ring_rd_q[SW-1:SAMPLE_BITS]));
        end
        if (!issue && !rd_pend_q) begin
          div_start = 1'b1;
          div_dvd   = 64'({mag_r, 8'd0});
          div_dvs   = 33'(wsat);
          sub_d     = 2'd0;
          state_d   = S_A_DIV;
        end
      end

      S_A_DIV: begin
        if (div_done) begin
          if (sub_q == 2'd0) begin
            ar_d      = div_quo[31:0];
            div_start = 1'b1;
            div_dvd   = 64'({mag_i, 8'd0});
            div_dvs   = 33'(wsat);
            sub_d     = 2'd1;
          end else begin
            ai_d    = div_quo[31:0];
            sub_d   = 2'd0;
            state_d = S_A_SQ;
          end
        end
      end

      S_A_SQ: begin
        case (sub_q)
          2'd0: begin
            mul_a = ar_q;
            mul_b = ar_q;
            sub_d = 2'd1;
          end
          2'd1: begin
            sq_d  = mul_q;
            mul_a = ai_q;
            mul_b = ai_q;
            sub_d = 2'd2;
          end
          2'd2: begin
            sq_d  = sq_q + mul_q;
            sub_d = 2'd3;
          end
          default: begin
            sq_start = 1'b1;
            state_d  = S_A_SQRT;
          end
        endcase
      end

      S_A_SQRT: begin
        if (sq_done) begin
          if (mean_sat > largest_q) largest_d = mean_sat;
          res_vld_d = 1'b1;
          state_d   = S_IDLE;
          if (total_q == TW'(MAX_WINDOWS)) begin
            res_d = mk(ST_FULL, '0, 1'b1);
          end else begin
            win_we          = 1'b1;
            win_waddr       = total_q[WAW-1:0];
            win_wdata.s_pos = start_q;
            win_wdata.e_pos = centre_q + {22'd0, half};
            win_wdata.mean  = mean_sat;
            total_d         = TW'(total_q + 1'b1);
            res_d           = mk(ST_OK, '0, 1'b1);
          end
        end
      end

      S_M_THR: begin
        if (sub_q == 2'd0) begin
          mul_a = {8'd0, largest_q};
          mul_b = {16'd0, scale_q};
          sub_d = 2'd1;
        end else begin
          thr_d = mul_q[39:0];
          if (total_q == '0) begin
            res_vld_d = 1'b1;
            res_d     = mk(ST_EMPTY, '0, 1'b1);
            state_d   = S_IDLE;
          end else begin
            win_re    = 1'b1;
            win_raddr = '0;
            j_d       = TW'(1);
            w_d       = '0;
            state_d   = S_M_LD0;
          end
        end
      end

      S_M_LD0: begin
        cur_d = win_rd_q;
        if (total_q > TW'(1)) begin
          win_re    = 1'b1;
          win_raddr = WAW'(1);
          state_d   = S_M_LD1;
        end else begin
          state_d = S_M_FLUSH;
        end
      end

      S_M_LD1: begin
        b_d     = win_rd_q;
        state_d = S_M_STEP;
      end

      S_M_STEP: begin
        win_re  = cvalid;
        state_d = S_M_EVAL;
      end

      S_M_EVAL: begin
        c_d = win_rd_q;
        if (join_ok) begin
          la_d    = cur_q.e_pos - cur_q.s_pos;
          lb_d    = b_q.e_pos - b_q.s_pos;
          sub_d   = 2'd0;
          state_d = S_M_MUL;
        end else begin
          win_we  = 1'b1;
          w_d     = TW'(w_q + 1'b1);
          cur_d   = b_q;
          b_d     = win_rd_q;
          j_d     = jn;
          state_d = (jn == total_q) ? S_M_FLUSH : S_M_STEP;
        end
      end

      S_M_MUL: begin
        case (sub_q)
          2'd0: begin
            mul_a = {8'd0, cur_q.mean};
            mul_b = la_q;
            sub_d = 2'd1;
          end
          2'd1: begin
            acc_d = mul_q;
            mul_a = {8'd0, b_q.mean};
            mul_b = lb_q;
            sub_d = 2'd2;
          end
          2'd2: begin
            acc_d  = acc_q + mul_q;
            slen_d = {1'b0, la_q} + {1'b0, lb_q};
            sub_d  = 2'd3;
          end
          default: begin
            if (slen_q != '0) begin
              div_start = 1'b1;
              state_d   = S_M_DIV;
            end else begin
              state_d = S_M_JOIN;
            end
          end
        endcase
      end

      S_M_DIV: begin
        if (div_done) begin
          cur_d.mean = div_quo[23:0];
          state_d    = S_M_JOIN;
        end
      end

      S_M_JOIN: begin
        cur_d.e_pos = b_q.e_pos;
        b_d         = c_q;
        j_d         = jn;
        state_d     = (jn == total_q) ? S_M_FLUSH : S_M_STEP;
      end

      S_M_FLUSH: begin
        win_we  = 1'b1;
        total_d = TW'(w_q + 1'b1);
        j_d     = '0;
        state_d = S_E_RD;
      end

      S_E_RD: begin
        win_re    = 1'b1;
        win_raddr = j_q[WAW-1:0];
        state_d   = S_E_OUT;
      end

      S_E_OUT: begin
        res_vld_d = 1'b1;
        res_d     = mk(ST_OK, win_rd_q, jn == total_q);
        if (jn == total_q) begin
          state_d = S_IDLE;
        end else begin
          j_d     = jn;
          state_d = S_E_RD;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      sub_q     <= 2'd0;
      ww_q      <= 11'd64;
      scale_q   <= 16'd128;
      pushed_q  <= '0;
      wr_ptr_q  <= '0;
      total_q   <= '0;
      largest_q <= '0;
      res_vld_q <= 1'b0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      sub_q     <= sub_d;
      ww_q      <= ww_d;
      scale_q   <= scale_d;
      pushed_q  <= pushed_d;
      wr_ptr_q  <= wr_ptr_d;
      total_q   <= total_d;
      largest_q <= largest_d;
      res_vld_q <= res_vld_d;
      rd_pend_q <= rd_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q    <= res_d;
    start_q  <= start_d;
    centre_q <= centre_d;
    skip_q   <= skip_d;
    diff_q   <= diff_d;
    raddr_q  <= raddr_d;
    cnt_q    <= cnt_d;
    sr_q     <= sr_d;
    si_q     <= si_d;
    ar_q     <= ar_d;
    ai_q     <= ai_d;
    sq_q     <= sq_d;
    thr_q    <= thr_d;
    j_q      <= j_d;
    w_q      <= w_d;
    cur_q    <= cur_d;
    b_q      <= b_d;
    c_q      <= c_d;
    la_q     <= la_d;
    lb_q     <= lb_d;
    acc_q    <= acc_d;
    slen_q   <= slen_d;
    mul_q    <= mul_a * mul_b;
  end

  // sample ring: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (ring_we) ring_mem[wr_ptr_q] <= ring_wdata;
    if (ring_re) ring_rd_q <= ring_mem[raddr_q];
  end

  // window list: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (win_we) win_mem[win_waddr] <= win_wdata;
    if (win_re) win_rd_q <= win_mem[win_raddr];
  end

  wesm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  wesm_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (sq_q),
    .done_o     (sq_done),
    .root_o     (sq_root)
  );

  assign busy_o         = state_q != S_IDLE;
  assign result_o       = res_q;
  assign result_valid_o = res_vld_q;

endmodule

`default_nettype wire

>>> hdl/wesm_checker.sv
// Port-level checks for the window energy segment merger, bound to the top level.
// Depends on wesm_pkg and the defines header.
`default_nettype none
`include "window_energy_segment_merger_unit_defines.svh"

module wesm_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           start_i,
  input wire wesm_pkg::in_t  item_i,
  input wire logic           busy_o,
  input wire wesm_pkg::out_t result_o,
  input wire logic           result_valid_o
);
  import wesm_pkg::*;

  // a beat that is not the last leaves the block still working
  `WESM_ASSERT_IMP(a_mid_beat_busy, result_valid_o && !result_o.last, busy_o)

  // a push answers in the very next cycle with a single beat
  `WESM_ASSERT_NXT(a_push_one_beat, start_i && !busy_o && (item_i.cmd == CMD_PUSH),
                   result_valid_o && result_o.last)

  // only beats with status OK can be followed by more beats
  `WESM_ASSERT_IMP(a_status_last, result_valid_o && (result_o.status != ST_OK),
                   result_o.last)

  // going idle always coincides with the final beat
  `WESM_ASSERT_IMP(a_idle_with_beat, $fell(busy_o), result_valid_o && result_o.last)

endmodule

bind window_energy_segment_merger_unit wesm_checker u_wesm_checker (.*);

`default_nettype wire
